[hw/rtl/gcpt_pkg.sv]
// Package with the widths, item types and arithmetic helpers of the changepoint prune test.
`default_nettype none
package gcpt_pkg;

	// Field formats.
	localparam int FRAC_BITS = 16;
	localparam int VALUE_WIDTH = 48;
	localparam int INDEX_WIDTH = 20;

	// Internal widths, derived from the field formats, except for the fixed limit width LIM_W.
	localparam int DIFF_W = VALUE_WIDTH + 1;
	localparam int DMAG_W = VALUE_WIDTH + 1;
	localparam int MEAN_W = VALUE_WIDTH + 2;
	localparam int SQ_IN_W = VALUE_WIDTH + 2;
	localparam int HALF_W = (SQ_IN_W + 1) / 2;
	localparam int PROD_W = 4 * HALF_W;
	localparam int LIM_W = 62;
	localparam int COST_W = LIM_W + 1;
	localparam int ACC_W = LIM_W + 2;
	localparam int ROOT_W = (LIM_W + FRAC_BITS + 1) / 2;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int DIV_N = DMAG_W;

	// Divider lanes.
	localparam int LANES = 4;
	localparam int LANE_MO = 0;
	localparam int LANE_MC = 1;
	localparam int LANE_QJI = 2;
	localparam int LANE_QIT = 3;

	localparam logic [LIM_W-1:0] LIM = {LIM_W{1'b1}};
	localparam logic signed [ACC_W-1:0] LIM_POS = $signed({{(ACC_W-LIM_W){1'b0}}, LIM});
	localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;
	localparam logic signed [ACC_W-1:0] VMAX =
		$signed({{(ACC_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] VMIN =
		$signed({{(ACC_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}});

	// One step of the four-lane restoring divider.
	typedef struct packed {
		logic [LANES-1:0][DMAG_W-1:0] num;
		logic [LANES-1:0][INDEX_WIDTH-1:0] rem;
		logic [LANES-1:0] neg;
		logic [INDEX_WIDTH-1:0] len_o;
		logic [INDEX_WIDTH-1:0] len_c;
		logic bad;
	} div_stage_t;

	// One step of the digit-by-digit square root, with the side data it carries.
	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [REM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
		logic signed [COST_W-1:0] cost_it;
		logic [SQ_IN_W-1:0] gap;
		logic use_root;
		logic bad;
	} root_stage_t;

	// Partial products of a square split into two halves.
	typedef struct packed {
		logic [2*HALF_W-1:0] hh;
		logic [2*HALF_W-1:0] hl;
		logic [2*HALF_W-1:0] ll;
	} sq_pp_t;

	// Shift in one numerator bit per lane and develop one quotient bit.
	function automatic div_stage_t div_step(div_stage_t s);
		div_stage_t r;
		logic [INDEX_WIDTH:0] trial;
		logic [INDEX_WIDTH-1:0] dvsr;
		logic ge;
		r = s;
		for (int l = 0; l < LANES; l++) begin
			dvsr = (l == LANE_MO || l == LANE_QIT) ? s.len_o : s.len_c;
			trial = {s.rem[l], s.num[l][DMAG_W-1]};
			ge = trial >= {1'b0, dvsr};
			r.rem[l] = ge ? INDEX_WIDTH'(trial - {1'b0, dvsr}) : trial[INDEX_WIDTH-1:0];
			r.num[l] = {s.num[l][DMAG_W-2:0], ge};
		end
		return r;
	endfunction

	// Bring down two radicand bits and develop one root bit.
	function automatic root_stage_t root_step(root_stage_t s);
		root_stage_t r;
		logic [REM_W+1:0] part;
		logic [REM_W+1:0] trial;
		logic ge;
		r = s;
		part = {s.rem, s.rad[RAD_W-1 -: 2]};
		trial = (REM_W+2)'({s.root, 2'b01});
		ge = part >= trial;
		r.rem = ge ? REM_W'(part - trial) : REM_W'(part);
		r.root = {s.root[ROOT_W-2:0], ge};
		r.rad = s.rad << 2;
		return r;
	endfunction

	// Magnitude of a signed value one bit wider than a mean.
	function automatic logic [SQ_IN_W-1:0] mag_of(logic signed [MEAN_W:0] x);
		logic signed [MEAN_W:0] n;
		n = -x;
		return x[MEAN_W] ? SQ_IN_W'(n) : SQ_IN_W'(x);
	endfunction

	// First half of a square: three half-width products.
	function automatic sq_pp_t sq_pp(logic [SQ_IN_W-1:0] m);
		sq_pp_t p;
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
		hi = HALF_W'(m >> HALF_W);
		lo = m[HALF_W-1:0];
		p.hh = hi * hi;
		p.hl = hi * lo;
		p.ll = lo * lo;
		return p;
	endfunction

	// Second half of a square: sum, drop the fraction and saturate.
	function automatic logic [LIM_W-1:0] sq_sum(sq_pp_t p);
		logic [PROD_W-1:0] full;
		logic [PROD_W-1:0] sh;
		full = (PROD_W'(p.hh) << (2 * HALF_W)) + (PROD_W'(p.hl) << (HALF_W + 1))
			+ PROD_W'(p.ll);
		sh = full >> FRAC_BITS;
		return (sh > PROD_W'(LIM)) ? LIM : LIM_W'(sh);
	endfunction

	// Add a quotient and a square, saturated to the intermediate range.
	function automatic logic signed [COST_W-1:0] cost_sum(logic signed [MEAN_W-1:0] q,
			logic [LIM_W-1:0] sq);
		logic signed [ACC_W-1:0] a;
		a = ACC_W'(q) + $signed(ACC_W'(sq));
		if (a > LIM_POS) begin
			a = LIM_POS;
		end else if (a < LIM_NEG) begin
			a = LIM_NEG;
		end
		return COST_W'(a);
	endfunction

endpackage
`default_nettype wire

[hw/rtl/gcpt_test_if.sv]
// Channel that carries one test item into the block.
`default_nettype none
interface gcpt_test_if;
	import gcpt_pkg::*;

	logic valid;
	logic ready;
	logic [INDEX_WIDTH-1:0] pos_t;
	logic [INDEX_WIDTH-1:0] pos_i;
	logic [INDEX_WIDTH-1:0] pos_j;
	logic signed [VALUE_WIDTH-1:0] sum_at_t;
	logic signed [VALUE_WIDTH-1:0] sum_at_i;
	logic signed [VALUE_WIDTH-1:0] sum_at_j;
	logic signed [VALUE_WIDTH-1:0] cost_at_i;
	logic signed [VALUE_WIDTH-1:0] cost_at_j;
	logic signed [VALUE_WIDTH-1:0] threshold;

	modport source (output valid, pos_t, pos_i, pos_j, sum_at_t, sum_at_i, sum_at_j,
		cost_at_i, cost_at_j, threshold, input ready);
	modport sink (input valid, pos_t, pos_i, pos_j, sum_at_t, sum_at_i, sum_at_j,
		cost_at_i, cost_at_j, threshold, output ready);
endinterface
`default_nettype wire

[hw/rtl/gcpt_result_if.sv]
// Channel that carries one result item out of the block.
`default_nettype none
interface gcpt_result_if;
	import gcpt_pkg::*;

	logic valid;
	logic ready;
	logic signed [VALUE_WIDTH-1:0] test_value;
	logic prune;
	logic bad_order;

	modport source (output valid, test_value, prune, bad_order, input ready);
	modport sink (input valid, test_value, prune, bad_order, output ready);
endinterface
`default_nettype wire

[hw/rtl/gaussian_changepoint_prune_test_unit.sv]
// Pipelined dual pruning test for a Gaussian mean-change segmentation.
//
// Items enter on the test channel and results leave on the result channel, both
// valid/ready; an item moves when valid and ready are high at a rising edge.
// Every test item gives exactly one result item, in order.
// The pipeline takes one item per cycle while the output is not held. An item passes
// from acceptance to the result channel through one input stage, 49 divider steps
// (one quotient bit per step in four lanes), five stages for means, squares and
// costs, 40 stages for the square root (one root bit per step), three stages
// for the last square and one output register.
// All stages move together: while the output register holds an item that the
// receiver does not take, the whole pipeline holds and test ready is low, so
// nothing is lost or repeated. As soon as the receiver takes the item, a new
// test item is accepted in the same cycle.
// When the positions do not satisfy t > i > j the result carries bad_order high
// with a zero test value and prune low.
// Reset clears the valid bits of all stages; the block is ready right after reset.
`default_nettype none
module gaussian_changepoint_prune_test_unit (
	input wire clk,
	input wire arst_n,
	gcpt_test_if.sink test,
	gcpt_result_if.source result
);
	import gcpt_pkg::*;

	logic adv;

	// Input stage and divider.
	logic signed [DIFF_W-1:0] diff_in [LANES];
	div_stage_t div_in;
	div_stage_t div_s [DIV_N+1];
	div_stage_t div_nxt [DIV_N];
	logic div_v [DIV_N+1];

	// Means, squares and costs.
	logic v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [MEAN_W-1:0] mo_s2, mc_s2, qji_s2, qit_s2;
	logic bad_s2;
	logic [SQ_IN_W-1:0] mag_o_s3, mag_c_s3, gap_s3;
	logic signed [MEAN_W-1:0] qji_s3, qit_s3;
	logic bad_s3;
	sq_pp_t pp_o_s4, pp_c_s4, pp_g_s4;
	logic signed [MEAN_W-1:0] qji_s4, qit_s4;
	logic [SQ_IN_W-1:0] gap_s4;
	logic bad_s4;
	logic [LIM_W-1:0] sq_o_s5, sq_c_s5, sq_g_s5;
	logic signed [MEAN_W-1:0] qji_s5, qit_s5;
	logic [SQ_IN_W-1:0] gap_s5;
	logic bad_s5;
	logic signed [COST_W-1:0] cji_s6, cit_s6;
	logic [LIM_W-1:0] sq_g_s6;
	logic [SQ_IN_W-1:0] gap_s6;
	logic bad_s6;

	// Square root.
	root_stage_t root_in;
	root_stage_t root_s [ROOT_W+1];
	root_stage_t root_nxt [ROOT_W];
	logic root_v [ROOT_W+1];

	// Last square and output.
	logic v_s8, v_s9, v_s10, v_s11;
	logic [SQ_IN_W-1:0] mag_d_s8;
	logic signed [COST_W-1:0] cit_s8, cit_s9, cit_s10;
	logic use_s8, use_s9, use_s10;
	logic bad_s8, bad_s9, bad_s10;
	sq_pp_t pp_d_s9;
	logic [LIM_W-1:0] sq_d_s10;
	logic signed [VALUE_WIDTH-1:0] value_s11;
	logic prune_s11, bad_s11;

	logic signed [SQ_IN_W:0] d_diff;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] sat;

	// The whole pipeline moves unless a finished item is held at the output.
	assign adv = !v_s11 || result.ready;
	assign test.ready = adv;

	// Differences of prefix sums and costs, split into sign and magnitude.
	always_comb begin
		diff_in[LANE_MO] = DIFF_W'(test.sum_at_t) - DIFF_W'(test.sum_at_i);
		diff_in[LANE_MC] = DIFF_W'(test.sum_at_i) - DIFF_W'(test.sum_at_j);
		diff_in[LANE_QJI] = DIFF_W'(test.cost_at_i) - DIFF_W'(test.cost_at_j);
		diff_in[LANE_QIT] = DIFF_W'(test.threshold) - DIFF_W'(test.cost_at_i);
		div_in = '0;
		for (int l = 0; l < LANES; l++) begin
			div_in.neg[l] = diff_in[l][DIFF_W-1];
			div_in.num[l] = diff_in[l][DIFF_W-1] ? DMAG_W'(-diff_in[l]) : DMAG_W'(diff_in[l]);
		end
		div_in.len_o = test.pos_t - test.pos_i;
		div_in.len_c = test.pos_i - test.pos_j;
		div_in.bad = !((test.pos_t > test.pos_i) && (test.pos_i > test.pos_j));
	end

	// Divider steps.
	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		assign div_nxt[k] = div_step(div_s[k]);
	end

	// Square-root steps.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		assign root_nxt[k] = root_step(root_s[k]);
	end

	// Radicand is the positive cost scaled by the fraction; the root is used
	// only when the cost exceeds the squared gap.
	always_comb begin
		root_in = '0;
		root_in.rad = (cji_s6 > 0) ? RAD_W'({cji_s6[LIM_W-1:0], {FRAC_BITS{1'b0}}}) : '0;
		root_in.cost_it = cit_s6;
		root_in.gap = gap_s6;
		root_in.use_root = ACC_W'(cji_s6) > $signed(ACC_W'(sq_g_s6));
		root_in.bad = bad_s6;
	end

	// Distance between the gap and the root.
	assign d_diff = $signed({1'b0, root_s[ROOT_W].gap}) - $signed((SQ_IN_W+1)'(root_s[ROOT_W].root));

	// Final value before the output register, saturated to the field width.
	always_comb begin
		if (use_s10) begin
			acc = $signed(ACC_W'(sq_d_s10)) - ACC_W'(cit_s10);
		end else begin
			acc = -ACC_W'(cit_s10);
		end
		sat = acc;
		if (acc > VMAX) begin
			sat = VMAX;
		end else if (acc < VMIN) begin
			sat = VMIN;
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_N; k++) div_v[k] <= 1'b0;
			for (int k = 0; k <= ROOT_W; k++) root_v[k] <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (adv) begin
			div_v[0] <= test.valid;
			for (int k = 0; k < DIV_N; k++) div_v[k+1] <= div_v[k];
			v_s2 <= div_v[DIV_N];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			root_v[0] <= v_s6;
			for (int k = 0; k < ROOT_W; k++) root_v[k+1] <= root_v[k];
			v_s8 <= root_v[ROOT_W];
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= div_in;
			for (int k = 0; k < DIV_N; k++) div_s[k+1] <= div_nxt[k];

			// Signed quotients, truncated toward zero.
			mo_s2 <= div_s[DIV_N].neg[LANE_MO] ? -MEAN_W'(div_s[DIV_N].num[LANE_MO])
				: MEAN_W'(div_s[DIV_N].num[LANE_MO]);
			mc_s2 <= div_s[DIV_N].neg[LANE_MC] ? -MEAN_W'(div_s[DIV_N].num[LANE_MC])
				: MEAN_W'(div_s[DIV_N].num[LANE_MC]);
			qji_s2 <= div_s[DIV_N].neg[LANE_QJI] ? -MEAN_W'(div_s[DIV_N].num[LANE_QJI])
				: MEAN_W'(div_s[DIV_N].num[LANE_QJI]);
			qit_s2 <= div_s[DIV_N].neg[LANE_QIT] ? -MEAN_W'(div_s[DIV_N].num[LANE_QIT])
				: MEAN_W'(div_s[DIV_N].num[LANE_QIT]);
			bad_s2 <= div_s[DIV_N].bad;

			// Magnitudes of the means and of their gap.
			mag_o_s3 <= mag_of((MEAN_W+1)'(mo_s2));
			mag_c_s3 <= mag_of((MEAN_W+1)'(mc_s2));
			gap_s3 <= mag_of((MEAN_W+1)'(mo_s2) - (MEAN_W+1)'(mc_s2));
			qji_s3 <= qji_s2;
			qit_s3 <= qit_s2;
			bad_s3 <= bad_s2;

			// Three squares, in two steps.
			pp_o_s4 <= sq_pp(mag_o_s3);
			pp_c_s4 <= sq_pp(mag_c_s3);
			pp_g_s4 <= sq_pp(gap_s3);
			qji_s4 <= qji_s3;
			qit_s4 <= qit_s3;
			gap_s4 <= gap_s3;
			bad_s4 <= bad_s3;

			sq_o_s5 <= sq_sum(pp_o_s4);
			sq_c_s5 <= sq_sum(pp_c_s4);
			sq_g_s5 <= sq_sum(pp_g_s4);
			qji_s5 <= qji_s4;
			qit_s5 <= qit_s4;
			gap_s5 <= gap_s4;
			bad_s5 <= bad_s4;

			// Normalized costs of both segments.
			cji_s6 <= cost_sum(qji_s5, sq_c_s5);
			cit_s6 <= cost_sum(qit_s5, sq_o_s5);
			sq_g_s6 <= sq_g_s5;
			gap_s6 <= gap_s5;
			bad_s6 <= bad_s5;

			root_s[0] <= root_in;
			for (int k = 0; k < ROOT_W; k++) root_s[k+1] <= root_nxt[k];

			// Squared distance between gap and root.
			mag_d_s8 <= d_diff[SQ_IN_W] ? SQ_IN_W'(-d_diff) : SQ_IN_W'(d_diff);
			cit_s8 <= root_s[ROOT_W].cost_it;
			use_s8 <= root_s[ROOT_W].use_root;
			bad_s8 <= root_s[ROOT_W].bad;

			pp_d_s9 <= sq_pp(mag_d_s8);
			cit_s9 <= cit_s8;
			use_s9 <= use_s8;
			bad_s9 <= bad_s8;

			sq_d_s10 <= sq_sum(pp_d_s9);
			cit_s10 <= cit_s9;
			use_s10 <= use_s9;
			bad_s10 <= bad_s9;

			// Output register.
			value_s11 <= bad_s10 ? '0 : VALUE_WIDTH'(sat);
			prune_s11 <= !bad_s10 && (sat > 0);
			bad_s11 <= bad_s10;
		end
	end

	assign result.valid = v_s11;
	assign result.test_value = value_s11;
	assign result.prune = prune_s11;
	assign result.bad_order = bad_s11;

endmodule
`default_nettype wire
